### hw/rtl/gss_pkg.sv
// shared types and constants for the gear shift servo sequencer
package gss_pkg;

   // field widths
   localparam int unsigned PULSE_W    = 16;
   localparam int unsigned DUR_W      = 8;
   localparam int unsigned LOCK_W     = 16;
   localparam int unsigned GEAR_W     = 3;
   localparam int unsigned RPM_W      = 16;
   localparam int unsigned TIME_W     = 8;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // shift behavior constants
   localparam logic [TIME_W-1:0] FLAT_SHIFT_DELAY = 8'd10;
   localparam logic [GEAR_W-1:0] TOP_GEAR         = 3'd6;
   localparam logic [GEAR_W-1:0] GEAR_NEUTRAL     = 3'd0;
   localparam logic [GEAR_W-1:0] GEAR_FIRST       = 3'd1;
   localparam logic [RPM_W-1:0]  FLAT_RPM_MIN     = 16'd3500;

   // transaction kind
   typedef enum logic {
      OP_CONTROL = 1'b0,
      OP_TICK    = 1'b1
   } op_type;

   // kind of shift in progress
   typedef enum logic [1:0] {
      KIND_DOWN    = 2'd0,
      KIND_NEUTRAL = 2'd1,
      KIND_UP      = 2'd2
   } shift_kind_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PULSE_UP       = 3'd0,
      CSR_PULSE_DOWN     = 3'd1,
      CSR_PULSE_NEUTRAL  = 3'd2,
      CSR_PULSE_MIDDLE   = 3'd3,
      CSR_DURATION_UP    = 3'd4,
      CSR_DURATION_DOWN  = 3'd5,
      CSR_UPSHIFT_LOCK   = 3'd6,
      CSR_DOWNSHIFT_LOCK = 3'd7
   } csr_index_type;

   // configuration register contents
   typedef struct packed {
      logic [PULSE_W-1:0] pulse_up;
      logic [PULSE_W-1:0] pulse_down;
      logic [PULSE_W-1:0] pulse_neutral;
      logic [PULSE_W-1:0] pulse_middle;
      logic [DUR_W-1:0]   duration_up;
      logic [DUR_W-1:0]   duration_down;
      logic [LOCK_W-1:0]  upshift_lock;
      logic [LOCK_W-1:0]  downshift_lock;
   } cfg_type;

   // one input transaction
   typedef struct packed {
      op_type             operation;
      logic               shift_up_req;
      logic               shift_down_req;
      logic [GEAR_W-1:0]  current_gear;
      logic [RPM_W-1:0]   engine_rpm;
      logic [TIME_W-1:0]  time_now;
   } item_type;

   // one result transaction
   typedef struct packed {
      logic [PULSE_W-1:0] servo_pulse;
      logic               flat_shift_on;
      logic               shift_locked;
      logic [GEAR_W-1:0]  target_gear;
   } result_type;

   // handshake between the input stage and the core
   typedef struct packed {
      logic valid;
      logic advance;
   } stage_ctl_type;

endpackage

### hw/rtl/gss_csr.sv
// configuration register file of the gear shift servo sequencer
module gss_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [gss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gss_pkg::CSR_DATA_W-1:0] csr_wdata,
   output gss_pkg::cfg_type               cfg
);

   gss_pkg::cfg_type cfg_ff;
   gss_pkg::cfg_type cfg_in;

   // decode the write into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (gss_pkg::csr_index_type'(csr_index))
            gss_pkg::CSR_PULSE_UP:       cfg_in.pulse_up       = csr_wdata;
            gss_pkg::CSR_PULSE_DOWN:     cfg_in.pulse_down     = csr_wdata;
            gss_pkg::CSR_PULSE_NEUTRAL:  cfg_in.pulse_neutral  = csr_wdata;
            gss_pkg::CSR_PULSE_MIDDLE:   cfg_in.pulse_middle   = csr_wdata;
            gss_pkg::CSR_DURATION_UP:    cfg_in.duration_up    =
               csr_wdata[gss_pkg::DUR_W-1:0];
            gss_pkg::CSR_DURATION_DOWN:  cfg_in.duration_down  =
               csr_wdata[gss_pkg::DUR_W-1:0];
            gss_pkg::CSR_UPSHIFT_LOCK:   cfg_in.upshift_lock   = csr_wdata;
            gss_pkg::CSR_DOWNSHIFT_LOCK: cfg_in.downshift_lock = csr_wdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   // register file, all fields clear on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/gss_in_stage.sv
// input register stage of the gear shift servo sequencer
module gss_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  gss_pkg::item_type     req_item,
   input  logic                  core_ready,
   output gss_pkg::item_type     item,
   output gss_pkg::stage_ctl_type ctl
);

   logic              valid_ff;
   logic              valid_in;
   gss_pkg::item_type item_ff;
   logic              advance;
   logic              take;

   // stage empties into the core when the core can load
   assign advance   = valid_ff && core_ready;
   assign req_ready = !valid_ff || core_ready;
   assign take      = req_valid && req_ready;

   // occupancy of the input register
   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

   assign item        = item_ff;
   assign ctl.valid   = valid_ff;
   assign ctl.advance = advance;

endmodule

### hw/rtl/gss_core.sv
// shift state update and result register of the gear shift servo sequencer
module gss_core (
   input  logic                   clock,
   input  logic                   reset,
   input  gss_pkg::cfg_type       cfg,
   input  gss_pkg::item_type      item,
   input  gss_pkg::stage_ctl_type ctl,
   output logic                   core_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output gss_pkg::result_type    rsp
);

   // shift state
   logic [gss_pkg::TIME_W-1:0]  start_time_ff,    start_time_in;
   gss_pkg::shift_kind_type     shift_kind_ff,    shift_kind_in;
   logic [gss_pkg::GEAR_W-1:0]  desired_gear_ff,  desired_gear_in;
   logic [gss_pkg::DUR_W-1:0]   hold_duration_ff, hold_duration_in;
   logic                        angle_latched_ff, angle_latched_in;
   logic                        locked_ff,        locked_in;
   logic [gss_pkg::LOCK_W-1:0]  lock_count_ff,    lock_count_in;
   logic [gss_pkg::PULSE_W-1:0] pulse_now_ff,     pulse_now_in;
   logic                        flat_active_ff,   flat_active_in;

   // result register
   logic                        rsp_valid_ff,     rsp_valid_in;
   gss_pkg::result_type         rsp_ff,           rsp_in;

   logic [gss_pkg::TIME_W-1:0]  elapsed;
   logic                        up_ok;
   logic                        down_ok;
   logic                        in_progress;

   assign core_ready = !rsp_valid_ff || rsp_ready;

   assign elapsed     = item.time_now - start_time_ff;
   assign up_ok       = item.shift_up_req && (item.current_gear < gss_pkg::TOP_GEAR);
   assign down_ok     = item.shift_down_req && (item.current_gear != gss_pkg::GEAR_NEUTRAL);
   assign in_progress = (elapsed < hold_duration_ff) &&
                        (desired_gear_ff != item.current_gear);

   // next shift state for the transaction in the input register
   always_comb begin
      start_time_in    = start_time_ff;
      shift_kind_in    = shift_kind_ff;
      desired_gear_in  = desired_gear_ff;
      hold_duration_in = hold_duration_ff;
      angle_latched_in = angle_latched_ff;
      locked_in        = locked_ff;
      lock_count_in    = lock_count_ff;
      pulse_now_in     = pulse_now_ff;
      flat_active_in   = flat_active_ff;
      if (item.operation == gss_pkg::OP_TICK) begin
         // lock countdown, release at zero
         if (lock_count_ff != '0) begin
            lock_count_in = lock_count_ff - 1'b1;
         end else begin
            locked_in = 1'b0;
         end
      end else if (!locked_ff && (item.shift_up_req || item.shift_down_req)) begin
         // new request, downshift wins over upshift
         start_time_in = item.time_now;
         if (down_ok) begin
            lock_count_in    = cfg.downshift_lock;
            locked_in        = 1'b1;
            hold_duration_in = cfg.duration_down;
            if (item.current_gear == gss_pkg::GEAR_FIRST) begin
               shift_kind_in   = gss_pkg::KIND_NEUTRAL;
               desired_gear_in = gss_pkg::GEAR_NEUTRAL;
            end else begin
               shift_kind_in   = gss_pkg::KIND_DOWN;
               desired_gear_in = item.current_gear - 1'b1;
            end
         end else if (up_ok) begin
            lock_count_in    = cfg.upshift_lock;
            locked_in        = 1'b1;
            hold_duration_in = cfg.duration_up;
            shift_kind_in    = gss_pkg::KIND_UP;
            desired_gear_in  = item.current_gear + 1'b1;
         end
      end else if (in_progress) begin
         // hold the shift position, add ignition cut when fast enough
         if (!angle_latched_ff) begin
            angle_latched_in = 1'b1;
            case (shift_kind_ff)
               gss_pkg::KIND_DOWN:    pulse_now_in = cfg.pulse_down;
               gss_pkg::KIND_NEUTRAL: pulse_now_in = cfg.pulse_neutral;
               gss_pkg::KIND_UP:      pulse_now_in = cfg.pulse_up;
               default:               pulse_now_in = pulse_now_ff;
            endcase
         end
         if ((elapsed > gss_pkg::FLAT_SHIFT_DELAY) &&
             (item.engine_rpm > gss_pkg::FLAT_RPM_MIN)) begin
            flat_active_in = 1'b1;
         end
      end else begin
         // back to the middle position
         flat_active_in   = 1'b0;
         pulse_now_in     = cfg.pulse_middle;
         angle_latched_in = 1'b0;
      end
   end

   // result shows the state after the update
   always_comb begin
      rsp_in.servo_pulse   = pulse_now_in;
      rsp_in.flat_shift_on = flat_active_in;
      rsp_in.shift_locked  = locked_in;
      rsp_in.target_gear   = desired_gear_in;
      rsp_valid_in         = rsp_valid_ff;
      if (ctl.advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // state registers, updated once per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         start_time_ff    <= '0;
         shift_kind_ff    <= gss_pkg::KIND_DOWN;
         desired_gear_ff  <= '0;
         hold_duration_ff <= '0;
         angle_latched_ff <= 1'b0;
         locked_ff        <= 1'b0;
         lock_count_ff    <= '0;
         pulse_now_ff     <= '0;
         flat_active_ff   <= 1'b0;
      end else if (ctl.advance) begin
         start_time_ff    <= start_time_in;
         shift_kind_ff    <= shift_kind_in;
         desired_gear_ff  <= desired_gear_in;
         hold_duration_ff <= hold_duration_in;
         angle_latched_ff <= angle_latched_in;
         locked_ff        <= locked_in;
         lock_count_ff    <= lock_count_in;
         pulse_now_ff     <= pulse_now_in;
         flat_active_ff   <= flat_active_in;
      end
   end

   // result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // ignition cut only while a shift position is latched
   a_flat_needs_angle: assert property (@(posedge clock) disable iff (reset)
      flat_active_ff |-> angle_latched_ff)
      else $error("flat shift active without latched position");

   // tick at zero count releases the lock
   a_tick_release: assert property (@(posedge clock) disable iff (reset)
      (ctl.advance && item.operation == gss_pkg::OP_TICK && lock_count_ff == '0)
      |=> !locked_ff)
      else $error("lock not released at zero count");

   // lock only engages on a control transaction
   a_lock_on_control: assert property (@(posedge clock) disable iff (reset)
      $rose(locked_ff) |-> $past(ctl.advance && item.operation == gss_pkg::OP_CONTROL))
      else $error("lock engaged without control transaction");

   // loaded result matches the updated state
   a_result_matches: assert property (@(posedge clock) disable iff (reset)
      ctl.advance |=> (rsp_ff.shift_locked == locked_ff) &&
                      (rsp_ff.target_gear == desired_gear_ff) &&
                      (rsp_ff.servo_pulse == pulse_now_ff))
      else $error("result register out of step with shift state");

   // the core only loads when the result register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !ctl.advance)
      else $error("pending result overwritten");

endmodule

### hw/rtl/gear_shift_servo_sequencer.sv
// top level of the gear shift servo sequencer
//
//   channel   ports         direction  flow control
//   request   req_*         in         valid / ready
//   response  rsp_*         out        valid / ready
//   csr       csr_*         in         write enable, no wait
//
// one transaction per cycle sustained unless the response stalls; a request
// goes through the input register, then the shift state update into the
// result register. the shift state update is a combinational compare and
// select path. synchronous active-high reset clears all shift state, the
// configuration registers and both valid flags. a stalled response holds in
// the result register while the input register still accepts one transaction.
module gear_shift_servo_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_operation,
   input  logic                            req_shift_up_req,
   input  logic                            req_shift_down_req,
   input  logic [gss_pkg::GEAR_W-1:0]      req_current_gear,
   input  logic [gss_pkg::RPM_W-1:0]       req_engine_rpm,
   input  logic [gss_pkg::TIME_W-1:0]      req_time_now,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [gss_pkg::PULSE_W-1:0]     rsp_servo_pulse,
   output logic                            rsp_flat_shift_on,
   output logic                            rsp_shift_locked,
   output logic [gss_pkg::GEAR_W-1:0]      rsp_target_gear,
   // configuration write port
   input  logic                            csr_wr_en,
   input  logic [gss_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gss_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   gss_pkg::cfg_type       cfg;
   gss_pkg::item_type      req_item;
   gss_pkg::item_type      item;
   gss_pkg::stage_ctl_type ctl;
   gss_pkg::result_type    rsp;
   logic                   core_ready;

   // pack the request fields
   always_comb begin
      req_item.operation      = gss_pkg::op_type'(req_operation);
      req_item.shift_up_req   = req_shift_up_req;
      req_item.shift_down_req = req_shift_down_req;
      req_item.current_gear   = req_current_gear;
      req_item.engine_rpm     = req_engine_rpm;
      req_item.time_now       = req_time_now;
   end

   gss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gss_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .core_ready (core_ready),
      .item       (item),
      .ctl        (ctl)
   );

   gss_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item       (item),
      .ctl        (ctl),
      .core_ready (core_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

   // unpack the response fields
   assign rsp_servo_pulse   = rsp.servo_pulse;
   assign rsp_flat_shift_on = rsp.flat_shift_on;
   assign rsp_shift_locked  = rsp.shift_locked;
   assign rsp_target_gear   = rsp.target_gear;

endmodule
